// ===== rtl/core/ffpa_pkg.sv =====
// Shared types, constants and handshake codes of the first-fit page allocator.
`default_nettype none

package ffpa_pkg;

  // Geometry
  localparam int PAGE_COUNT_DEF  = 32;
  localparam int PAGE_BYTES      = 4096;
  localparam int MAX_ALLOC_BYTES = 8192;
  localparam int PB_SH           = $clog2(PAGE_BYTES);
  localparam int MAX_PAGES       = (MAX_ALLOC_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int NEED_W          = $clog2(MAX_PAGES + 1);
  localparam int USE_W           = $clog2(PAGE_BYTES + 1);

  // Field widths
  localparam int ACT_W        = 2;
  localparam int BYTES_W      = 14;
  localparam int ID_W         = 16;
  localparam int IDX_W        = 5;
  localparam int STATUS_W     = 3;
  localparam int CNT_OUT_W    = 2;
  localparam int USED_OUT_W   = 13;
  localparam int STATE_OUT_W  = 2;
  localparam int CNT_OUT_MAX  = 3;
  localparam int USED_OUT_MAX = 8191;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_IDS_OUT   = 3'd4
  } status_t;

  typedef enum logic [STATE_OUT_W-1:0] {
    PS_FREE    = 2'd0,
    PS_PARTIAL = 2'd1,
    PS_FULL    = 2'd2
  } page_state_t;

  typedef enum logic [1:0] {
    RK_ERR   = 2'd0,
    RK_ALLOC = 2'd1,
    RK_FREE  = 2'd2,
    RK_READ  = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BYTES_W-1:0] alloc_bytes;
    logic [ID_W-1:0]    free_id;
    logic [IDX_W-1:0]   page_index;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ID_W-1:0]        result_id;
    logic [IDX_W-1:0]       run_start;
    logic [CNT_OUT_W-1:0]   page_count;
    logic [USED_OUT_W-1:0]  page_bytes_used;
    logic [STATE_OUT_W-1:0] page_state;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    logic      clear_wr;
    logic      scan;
    logic      sweep;
    logic      take_id;
    logic      alloc_wr;
    logic      rd_issue;
    logic      set_res;
    res_kind_t res_kind;
    status_t   res_code;
    logic      emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             bad_size;
    logic             need_big;
    logic             id_zero;
    logic             idx_out;
    logic             clear_last;
    logic             found;
    logic             walk_end;
    logic             ids_out;
    logic             wr_last;
    logic             count_zero;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffpa_req_if.sv =====
// Request channel: valid/ready handshake carrying one request item.
`default_nettype none

interface ffpa_req_if import ffpa_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffpa_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
`default_nettype none

interface ffpa_rsp_if import ffpa_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ffpa_ctrl.sv =====
// Sequencing state machine of the allocator: clear pass, decode, scan, write, sweep, read.
`default_nettype none

module ffpa_ctrl import ffpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_DECODE    = 9'b000000100,
    S_SCAN      = 9'b000001000,
    S_WRITE     = 9'b000010000,
    S_SWEEP     = 9'b000100000,
    S_READ      = 9'b001000000,
    S_READ_WAIT = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_kind = RK_ERR;
    cmd.res_code = ST_OK;
    req_ready    = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.act)
          ACT_ALLOC: begin
            if (sts.bad_size) begin
              cmd.set_res = 1'b1;
              cmd.res_code = ST_BAD_SIZE;
              state_next = S_DONE;
            end else if (sts.need_big) begin
              cmd.set_res = 1'b1;
              cmd.res_code = ST_NO_FIT;
              state_next = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end
          ACT_FREE: begin
            // id 0 would match every free page
            if (sts.id_zero) begin
              cmd.set_res = 1'b1;
              cmd.res_code = ST_NOT_FOUND;
              state_next = S_DONE;
            end else begin
              state_next = S_SWEEP;
            end
          end
          ACT_READ: begin
            if (sts.idx_out) begin
              cmd.set_res = 1'b1;
              state_next = S_DONE;
            end else begin
              state_next = S_READ;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          if (sts.ids_out) begin
            cmd.set_res = 1'b1;
            cmd.res_code = ST_IDS_OUT;
            state_next = S_DONE;
          end else begin
            cmd.take_id = 1'b1;
            state_next = S_WRITE;
          end
        end else if (sts.walk_end) begin
          cmd.set_res = 1'b1;
          cmd.res_code = ST_NO_FIT;
          state_next = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.alloc_wr = 1'b1;
        if (sts.wr_last) begin
          cmd.set_res = 1'b1;
          cmd.res_kind = RK_ALLOC;
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.walk_end) begin
          cmd.set_res = 1'b1;
          if (sts.count_zero) begin
            cmd.res_code = ST_NOT_FOUND;
          end else begin
            cmd.res_kind = RK_FREE;
          end
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        cmd.set_res = 1'b1;
        cmd.res_kind = RK_READ;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffpa_dpath.sv =====
// Page tables, walk counter, run tracking, id counter and result register.
`default_nettype none

module ffpa_dpath import ffpa_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  req_item_t req_data,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_data
);

  localparam int PW = $clog2(PAGE_COUNT);
  localparam logic [PW-1:0] LAST = PW'(PAGE_COUNT - 1);

  // Page tables
  logic [ID_W-1:0]  owner_mem [PAGE_COUNT];
  logic [USE_W-1:0] usage_mem [PAGE_COUNT];
  logic [ID_W-1:0]  owner_rd;
  logic [USE_W-1:0] usage_rd;

  // Captured request
  logic [ACT_W-1:0]   act_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [ID_W-1:0]    id_q;
  logic [IDX_W-1:0]   idx_q;
  logic [NEED_W-1:0]  need_q;
  logic               bad_q;

  // Walk and control
  logic [PW-1:0]     addr;
  logic [PW-1:0]     pend_addr;
  logic [PW-1:0]     start;
  logic              pend;
  logic              issue_done;
  logic              found;
  logic              walk_end;
  logic [NEED_W-1:0] run;
  logic [NEED_W-1:0] wcnt;
  logic [1:0]        count;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   alloc_id;
  res_kind_t         res_kind;
  status_t           res_code;

  logic [BYTES_W:0]   need_sum;
  logic [NEED_W-1:0]  need_in;
  logic               bad_in;
  logic               addr_last;
  logic               walk_re;
  logic               sweep_hit;
  logic [NEED_W-1:0]  run_inc;
  logic               mem_we;
  logic               mem_re;
  logic [PW-1:0]      wa;
  logic [PW-1:0]      ra;
  logic [ID_W-1:0]    owner_wd;
  logic [USE_W-1:0]   usage_wd;
  logic [USE_W-1:0]   last_use;
  logic [USE_W-1:0]   rem;
  rsp_item_t          res;

  always_comb begin
    need_sum = {1'b0, req_data.alloc_bytes} + (BYTES_W + 1)'(PAGE_BYTES - 1);
    need_in  = NEED_W'(need_sum >> PB_SH);
    bad_in   = (req_data.alloc_bytes == '0) ||
               (32'(req_data.alloc_bytes) > MAX_ALLOC_BYTES);
  end

  assign addr_last = (addr == LAST);
  assign walk_re   = (cmd.scan || cmd.sweep) && !issue_done;
  assign sweep_hit = cmd.sweep && pend && (owner_rd == id_q);
  assign run_inc   = NEED_W'(run + 1'b1);

  assign rem      = USE_W'(bytes_q[PB_SH-1:0]);
  assign last_use = (rem == '0) ? USE_W'(PAGE_BYTES) : rem;

  always_comb begin
    mem_we   = cmd.clear_wr || cmd.alloc_wr || sweep_hit;
    wa       = sweep_hit ? pend_addr : addr;
    owner_wd = cmd.alloc_wr ? alloc_id : '0;
    usage_wd = '0;
    if (cmd.alloc_wr) begin
      usage_wd = sts.wr_last ? last_use : USE_W'(PAGE_BYTES);
    end
    mem_re = walk_re || cmd.rd_issue;
    ra     = cmd.rd_issue ? PW'(idx_q) : addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[wa] <= owner_wd;
      usage_mem[wa] <= usage_wd;
    end
    if (mem_re) begin
      owner_rd <= owner_mem[ra];
      usage_rd <= usage_mem[ra];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      pend       <= 1'b0;
      issue_done <= 1'b0;
      found      <= 1'b0;
      walk_end   <= 1'b0;
      run        <= '0;
      wcnt       <= '0;
      count      <= '0;
      next_id    <= ID_W'(1);
      rsp_valid  <= 1'b0;
    end else begin
      pend <= walk_re;
      if (cmd.capture) begin
        addr       <= '0;
        issue_done <= 1'b0;
        found      <= 1'b0;
        walk_end   <= 1'b0;
        run        <= '0;
        count      <= '0;
      end else if (cmd.take_id) begin
        addr    <= start;
        wcnt    <= '0;
        next_id <= ID_W'(next_id + 1'b1);
      end else if (cmd.clear_wr || cmd.alloc_wr) begin
        addr <= PW'(addr + 1'b1);
        wcnt <= NEED_W'(wcnt + 1'b1);
      end else if (walk_re) begin
        addr       <= PW'(addr + 1'b1);
        issue_done <= addr_last;
      end

      // first fit: the earliest window of free pages ends at the first full run
      if (cmd.scan && pend && !found) begin
        if (owner_rd == '0) begin
          run <= run_inc;
          if (run_inc == need_q) begin
            found <= 1'b1;
          end else if (pend_addr == LAST) begin
            walk_end <= 1'b1;
          end
        end else begin
          run <= '0;
          if (pend_addr == LAST) begin
            walk_end <= 1'b1;
          end
        end
      end

      if (cmd.sweep && pend) begin
        if (sweep_hit && count != 2'd3) begin
          count <= 2'(count + 1'b1);
        end
        if (pend_addr == LAST) begin
          walk_end <= 1'b1;
        end
      end

      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q   <= req_data.action;
      bytes_q <= req_data.alloc_bytes;
      id_q    <= req_data.free_id;
      idx_q   <= req_data.page_index;
      need_q  <= need_in;
      bad_q   <= bad_in;
    end
    if (walk_re) begin
      pend_addr <= addr;
    end
    if (cmd.scan && pend && !found && owner_rd == '0 && run_inc == need_q) begin
      start <= PW'(pend_addr - PW'(need_q) + 1'b1);
    end
    if (cmd.take_id) begin
      alloc_id <= next_id;
    end
    if (cmd.set_res) begin
      res_kind <= cmd.res_kind;
      res_code <= cmd.res_code;
    end
    if (cmd.emit) begin
      rsp_data <= res;
    end
  end

  always_comb begin
    res        = '0;
    res.status = res_code;
    case (res_kind)
      RK_ERR: begin
        res.status = res_code;
      end
      RK_ALLOC: begin
        res.status     = ST_OK;
        res.result_id  = alloc_id;
        res.run_start  = IDX_W'(start);
        res.page_count = (32'(need_q) > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX)
                                                     : CNT_OUT_W'(need_q);
      end
      RK_FREE: begin
        res.status     = ST_OK;
        res.result_id  = id_q;
        res.page_count = count;
      end
      RK_READ: begin
        res.status          = ST_OK;
        res.result_id       = owner_rd;
        res.page_bytes_used = (32'(usage_rd) > USED_OUT_MAX) ? USED_OUT_W'(USED_OUT_MAX)
                                                             : USED_OUT_W'(usage_rd);
        if (owner_rd == '0) begin
          res.page_state = PS_FREE;
        end else if (usage_rd == USE_W'(PAGE_BYTES)) begin
          res.page_state = PS_FULL;
        end else begin
          res.page_state = PS_PARTIAL;
        end
      end
      default: begin
        res.status = res_code;
      end
    endcase
  end

  always_comb begin
    sts            = '0;
    sts.act        = act_q;
    sts.bad_size   = bad_q;
    sts.need_big   = 32'(need_q) > PAGE_COUNT;
    sts.id_zero    = (id_q == '0);
    sts.idx_out    = 32'(idx_q) >= PAGE_COUNT;
    sts.clear_last = addr_last;
    sts.found      = found;
    sts.walk_end   = walk_end;
    sts.ids_out    = (next_id == '0);
    sts.wr_last    = (NEED_W'(wcnt + 1'b1) == need_q);
    sts.count_zero = (count == '0);
    sts.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_page_allocator_unit.sv =====
// First-fit contiguous page allocator: top level joining controller and datapath.
//
// req carries one request beat: action (allocate, free by id, read page),
// alloc_bytes, free_id and page_index. rsp returns exactly one result beat
// per request: status, result_id, run_start, page_count, page_bytes_used
// and page_state. Both channels use valid/ready; a beat moves when both are high.
//
// One request is in flight at a time. Allocate reads the page table in a
// first-fit scan (one page table read per cycle) that stops at the first
// fitting run, then does one write per page of the run; free visits every
// page (one page visited per cycle). The page table port paces both walks.
// Once the result is registered, the controller is idle and ready for the
// next request.
//
// After reset the page tables are cleared one page per cycle, so req.ready
// stays low until every page has been cleared; ids restart at 1.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and only its result waits.
`default_nettype none

module first_fit_page_allocator_unit import ffpa_pkg::*; #(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  ffpa_req_if.sink   req,
  ffpa_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffpa_dpath #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
  );

endmodule

`default_nettype wire

// ===== bench/tb_first_fit_page_allocator_unit.sv =====
// Self-checking testbench for the first-fit page allocator: directed table and random mix.
module tb_first_fit_page_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpa_pkg::*;

  localparam int NPAGES = PAGE_COUNT_DEF;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    req_item_t req;
    bit        typed;
    rsp_item_t exp;
  } dir_row_t;

  logic clk;
  logic rst;

  ffpa_req_if req_if ();
  ffpa_rsp_if rsp_if ();

  first_fit_page_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Shadow page tables
  logic [ID_W-1:0]       owner_tbl [NPAGES];
  logic [USED_OUT_W-1:0] used_tbl [NPAGES];
  logic [ID_W-1:0]       id_next;

  rsp_item_t expected_outcomes [$];
  dir_row_t  dir_rows [$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        beats_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("tb_first_fit_page_allocator_unit: errors");
    $finish;
  end

  function automatic rsp_item_t outcome(input status_t st, input int id, input int sp,
                                        input int pc, input int used, input page_state_t ps);
    rsp_item_t r;
    r.status          = st;
    r.result_id       = ID_W'(id);
    r.run_start       = IDX_W'(sp);
    r.page_count      = CNT_OUT_W'(pc);
    r.page_bytes_used = USED_OUT_W'(used);
    r.page_state      = ps;
    return r;
  endfunction

  // Updates the shadow tables and returns the result the block should give.
  function automatic rsp_item_t allocator_outcome(input req_item_t it);
    rsp_item_t r;
    int need;
    int first;
    int freed;
    int rem;
    bit fit;
    r = '0;
    case (it.action)
      ACT_ALLOC: begin
        if (it.alloc_bytes == 0 || int'(it.alloc_bytes) > MAX_ALLOC_BYTES) begin
          r.status = ST_BAD_SIZE;
        end else begin
          need  = (int'(it.alloc_bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
          first = -1;
          for (int s = 0; s + need <= NPAGES && first < 0; s++) begin
            fit = 1'b1;
            for (int j = 0; j < need; j++)
              if (owner_tbl[s + j] != 0) fit = 1'b0;
            if (fit) first = s;
          end
          if (first < 0) begin
            r.status = ST_NO_FIT;
          end else if (id_next == 0) begin
            r.status = ST_IDS_OUT;
          end else begin
            rem = int'(it.alloc_bytes) % PAGE_BYTES;
            for (int j = 0; j < need; j++) begin
              owner_tbl[first + j] = id_next;
              used_tbl[first + j]  =
                USED_OUT_W'((j < need - 1 || rem == 0) ? PAGE_BYTES : rem);
            end
            r.status     = ST_OK;
            r.result_id  = id_next;
            r.run_start  = IDX_W'(first);
            r.page_count = CNT_OUT_W'(need);
            id_next      = id_next + 16'd1;
          end
        end
      end
      ACT_FREE: begin
        freed = 0;
        if (it.free_id != 0) begin
          for (int p = 0; p < NPAGES; p++) begin
            if (owner_tbl[p] == it.free_id) begin
              owner_tbl[p] = '0;
              used_tbl[p]  = '0;
              freed++;
            end
          end
        end
        if (freed == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status     = ST_OK;
          r.result_id  = it.free_id;
          r.page_count = CNT_OUT_W'((freed > CNT_OUT_MAX) ? CNT_OUT_MAX : freed);
        end
      end
      ACT_READ: begin
        r.status          = ST_OK;
        r.result_id       = owner_tbl[it.page_index];
        r.page_bytes_used = used_tbl[it.page_index];
        if (owner_tbl[it.page_index] == 0)
          r.page_state = PS_FREE;
        else if (int'(used_tbl[it.page_index]) == PAGE_BYTES)
          r.page_state = PS_FULL;
        else
          r.page_state = PS_PARTIAL;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Fields the action does not use get random values.
  function automatic req_item_t make_req(input logic [ACT_W-1:0] act, input int arg);
    req_item_t it;
    it.action      = act;
    it.alloc_bytes = BYTES_W'($urandom_range(0, 16383));
    it.free_id     = ID_W'($urandom_range(0, 65535));
    it.page_index  = IDX_W'($urandom_range(0, NPAGES - 1));
    case (act)
      ACT_ALLOC: it.alloc_bytes = arg[BYTES_W-1:0];
      ACT_FREE:  it.free_id = arg[ID_W-1:0];
      ACT_READ:  it.page_index = arg[IDX_W-1:0];
      default:   ;
    endcase
    return it;
  endfunction

  function automatic void add_row(input logic [ACT_W-1:0] act, input int arg,
                                  input bit typed, input rsp_item_t exp);
    dir_row_t row;
    row.req   = make_req(act, arg);
    row.typed = typed;
    row.exp   = exp;
    dir_rows.push_back(row);
  endfunction

  function automatic int pick_size();
    int roll;
    int sz;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      sz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_ALLOC_BYTES + 1, 16383);
    end else if (roll < 22) begin
      case ($urandom_range(0, 5))
        0:       sz = 1;
        1:       sz = PAGE_BYTES - 1;
        2:       sz = PAGE_BYTES;
        3:       sz = PAGE_BYTES + 1;
        4:       sz = MAX_ALLOC_BYTES - 1;
        default: sz = MAX_ALLOC_BYTES;
      endcase
    end else begin
      sz = $urandom_range(1, MAX_ALLOC_BYTES);
    end
    return sz;
  endfunction

  // Alternates fill-heavy and drain-heavy stretches so the store both fills and empties.
  function automatic req_item_t random_request();
    int roll;
    int alloc_pct;
    int free_pct;
    bit filling;
    logic [ID_W-1:0] id;
    filling   = ((beats_sent / 120) % 2) == 0;
    alloc_pct = filling ? 55 : 25;
    free_pct  = filling ? 20 : 45;
    roll      = $urandom_range(0, 99);
    if (roll < alloc_pct)
      return make_req(ACT_ALLOC, pick_size());
    if (roll < alloc_pct + free_pct) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)
        id = '0;
      else if (roll < 25)
        id = ID_W'($urandom_range(0, 65535));
      else
        id = id_next - 16'd1 - 16'($urandom_range(0, 24));
      return make_req(ACT_FREE, int'(id));
    end
    if (roll >= 96)
      return make_req(ACT_UNUSED, 0);
    return make_req(ACT_READ, $urandom_range(0, NPAGES - 1));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic drive_request(input req_item_t it, input bit typed, input rsp_item_t exp);
    rsp_item_t pred;
    while (!(beats_sent >= 500 && beats_sent < 800) && $urandom_range(0, 99) < 6) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pred = allocator_outcome(it);
    expected_outcomes.push_back(typed ? exp : pred);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Result side: random stalls, one long hold-off, and a stretch with no stalls.
  initial begin : result_sink
    rsp_item_t want;
    rsp_item_t got;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (beats_seen >= 300 && !held) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (beats_seen >= 500 && beats_seen < 800) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 6);
      end
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        beats_seen++;
        if (expected_outcomes.size() == 0) begin
          $error("result beat with no request waiting");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          got  = rsp_if.data;
          check_field("status", int'(want.status), int'(got.status));
          check_field("result_id", int'(want.result_id), int'(got.result_id));
          check_field("run_start", int'(want.run_start), int'(got.run_start));
          check_field("page_count", int'(want.page_count), int'(got.page_count));
          check_field("page_bytes_used", int'(want.page_bytes_used),
                      int'(got.page_bytes_used));
          check_field("page_state", int'(want.page_state), int'(got.page_state));
        end
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    for (int p = 0; p < NPAGES; p++) begin
      owner_tbl[p] = '0;
      used_tbl[p]  = '0;
    end
    id_next = 16'd1;

    // Fresh store, edge sizes, bad ids, unused action
    add_row(ACT_READ, 0, 1, outcome(ST_OK, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_READ, NPAGES - 1, 1, outcome(ST_OK, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_ALLOC, 0, 1, outcome(ST_BAD_SIZE, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_ALLOC, MAX_ALLOC_BYTES + 1, 1, outcome(ST_BAD_SIZE, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_ALLOC, 16383, 1, outcome(ST_BAD_SIZE, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_FREE, 0, 1, outcome(ST_NOT_FOUND, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_FREE, 65535, 1, outcome(ST_NOT_FOUND, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_UNUSED, 0, 1, outcome(ST_OK, 0, 0, 0, 0, PS_FREE));
    add_row(ACT_ALLOC, 1, 1, outcome(ST_OK, 1, 0, 1, 0, PS_FREE));
    add_row(ACT_ALLOC, MAX_ALLOC_BYTES, 1, outcome(ST_OK, 2, 1, 2, 0, PS_FREE));
    add_row(ACT_ALLOC, PAGE_BYTES, 0, '0);
    add_row(ACT_ALLOC, PAGE_BYTES + 1, 0, '0);
    add_row(ACT_READ, 0, 0, '0);
    add_row(ACT_READ, 2, 0, '0);
    add_row(ACT_READ, 3, 0, '0);
    add_row(ACT_READ, 5, 0, '0);
    add_row(ACT_FREE, 2, 0, '0);
    add_row(ACT_READ, 1, 0, '0);
    // hole left by id 2 is reused first
    add_row(ACT_ALLOC, MAX_ALLOC_BYTES, 0, '0);
    add_row(ACT_FREE, 3, 0, '0);
    add_row(ACT_ALLOC, PAGE_BYTES - 1, 0, '0);
    add_row(ACT_READ, 3, 0, '0);
    add_row(ACT_FREE, 1, 0, '0);
    add_row(ACT_ALLOC, 12, 0, '0);
    add_row(ACT_READ, NPAGES - 1, 0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      drive_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

    // sender holds until the block has drained
    req_if.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
    @(negedge clk);

    repeat (RANDOM_ITEMS) drive_request(random_request(), 0, '0);

    // Empty the store, then a few edge requests on the empty store
    for (int p = 0; p < NPAGES; p++)
      if (owner_tbl[p] != 0) drive_request(make_req(ACT_FREE, int'(owner_tbl[p])), 0, '0);

    drive_request(make_req(ACT_ALLOC, 1), 0, '0);
    drive_request(make_req(ACT_FREE, 65535), 0, '0);
    drive_request(make_req(ACT_ALLOC, 100), 0, '0);
    drive_request(make_req(ACT_ALLOC, MAX_ALLOC_BYTES), 0, '0);
    drive_request(make_req(ACT_ALLOC, 0), 0, '0);
    drive_request(make_req(ACT_READ, NPAGES - 2), 0, '0);
    drive_request(make_req(ACT_READ, 0), 0, '0);
    repeat (60) drive_request(random_request(), 0, '0);

    req_if.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_first_fit_page_allocator_unit: clean");
    else
      $display("tb_first_fit_page_allocator_unit: errors");
    $finish;
  end

endmodule
